>>> src/round_robin_server_pool_defines.svh
// ----------------------------------------------------------------------------
// round robin server pool: assertion macros
// shared checking macros for the server pool rtl
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SERVER_POOL_DEFINES_SVH
`define ROUND_ROBIN_SERVER_POOL_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RRSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RRSP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RRSP_ASSERT(lbl, prop, msg)
`define RRSP_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// types and constants shared by the server pool controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package rrsp_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned ROT_W     = 16;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned STAT_W    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_PICK = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    RD_LAST = 1'b0,
    RD_REM  = 1'b1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_COUNT = 2'd0,
    WR_HIT   = 2'd1,
    WR_LAST  = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    DATA_ID    = 2'd0,
    DATA_MOVED = 2'd1,
    DATA_ZERO  = 2'd2
  } data_sel_e;

  typedef struct packed {
    logic      scan_en;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    data_sel_e data_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      rem_start;
    logic      load_out;
    status_e   status;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e act;
    logic    hit;
    logic    exhausted;
    logic    full;
    logic    empty;
    logic    rem_done;
    logic    out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/round_robin_server_pool.sv
// ----------------------------------------------------------------------------
// round_robin_server_pool
// compact pool of server identifiers with round-robin pick
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  input    | in_valid_i / in_stall_o  | action_i, server_id_i
//  output   | out_valid_o / out_stall_i| picked_server_o, status_o, pool_count_o
//  config   | cfg_we_i                 | cfg_capacity_i
//
//  one word at a time; add and delete run a linear scan of the pool over
//  the single read port of the slot memory; pick waits on the bit-serial
//  remainder unit (16 steps); a finished word waits in the output register
//  while the next word is taken
//  reset clears count and rotation, sets capacity to 64; slots need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_server_pool #(
  parameter int unsigned MAX_SERVERS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [rrsp_pkg::ID_W-1:0]      server_id_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [rrsp_pkg::ID_W-1:0]           picked_server_o,
  output logic [rrsp_pkg::STAT_W-1:0]         status_o,
  output logic [rrsp_pkg::OUT_CNT_W-1:0]      pool_count_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrsp_pkg::CAP_W-1:0]     cfg_capacity_i
);

  logic                 in_accept;
  rrsp_pkg::ctrl_cmd_t  cmd;
  rrsp_pkg::dp_status_t dp_st;

  assign in_accept = in_valid_i && !in_stall_o;

  rrsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .st_i        (dp_st),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  rrsp_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_accept_i     (in_accept),
    .action_i        (action_i),
    .server_id_i     (server_id_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_capacity_i  (cfg_capacity_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .st_o            (dp_st),
    .out_valid_o     (out_valid_o),
    .picked_server_o (picked_server_o),
    .status_o        (status_o),
    .pool_count_o    (pool_count_o)
  );

endmodule

`default_nettype wire

>>> src/rrsp_rem_unit.sv
// ----------------------------------------------------------------------------
// rrsp_rem_unit
// bit-serial restoring remainder of the rotation counter by the pool count
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_server_pool_defines.svh"

module rrsp_rem_unit #(
  parameter int unsigned DIV_W = 7
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rrsp_pkg::ROT_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0]          divisor_i,
  output logic                           done_o,
  output logic [DIV_W-1:0]               rem_o
);

  localparam int unsigned DVD_W  = rrsp_pkg::ROT_W;
  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;

  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = shifted - (DIV_W + 1)'(divisor_i);
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d  = (shifted >= (DIV_W + 1)'(divisor_i)) ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `RRSP_ASSERT(a_rem_below_divisor, done_q |-> (rem_q < divisor_i), "remainder not below divisor")

endmodule

`default_nettype wire

>>> src/rrsp_datapath.sv
// ----------------------------------------------------------------------------
// rrsp_datapath
// slot memory, pool count, rotation counter, scan logic and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_server_pool_defines.svh"

module rrsp_datapath #(
  parameter int unsigned MAX_SERVERS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_accept_i,
  input  wire logic [1:0]                    action_i,
  input  wire logic [rrsp_pkg::ID_W-1:0]     server_id_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrsp_pkg::CAP_W-1:0]    cfg_capacity_i,
  input  wire logic                          out_stall_i,
  input  wire rrsp_pkg::ctrl_cmd_t           cmd_i,
  output rrsp_pkg::dp_status_t               st_o,
  output logic                               out_valid_o,
  output logic [rrsp_pkg::ID_W-1:0]          picked_server_o,
  output logic [rrsp_pkg::STAT_W-1:0]        status_o,
  output logic [rrsp_pkg::OUT_CNT_W-1:0]     pool_count_o
);

  localparam int unsigned ID_W      = rrsp_pkg::ID_W;
  localparam int unsigned ROT_W     = rrsp_pkg::ROT_W;
  localparam int unsigned CAP_W     = rrsp_pkg::CAP_W;
  localparam int unsigned OUT_CNT_W = rrsp_pkg::OUT_CNT_W;
  localparam int unsigned IDX_W     = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_SERVERS + 1);
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [ID_W-1:0]       slots_q [MAX_SERVERS];

  rrsp_pkg::action_e     act_q;
  logic [ID_W-1:0]       id_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ROT_W-1:0]      rot_q, rot_d;
  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic                  cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [ID_W-1:0]       rd_q;
  logic                  out_valid_q, out_valid_d;
  logic [ID_W-1:0]       picked_q;
  logic [rrsp_pkg::STAT_W-1:0] status_q;
  logic [OUT_CNT_W-1:0]  pool_count_q;

  logic                  ptr_lt;
  logic                  scan_issue;
  logic                  rd_fire;
  logic [CNT_W-1:0]      last_cnt;
  logic [IDX_W-1:0]      last_idx;
  logic [CNT_W-1:0]      rem;
  logic                  rem_done;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [ID_W-1:0]       wr_data;
  logic                  full;
  logic                  pick_ok;

  rrsp_rem_unit #(
    .DIV_W (CNT_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (rot_q),
    .divisor_i  (count_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_comb begin
    ptr_lt     = ptr_q < count_q;
    scan_issue = cmd_i.scan_en && ptr_lt;
    rd_fire    = scan_issue || cmd_i.rd_en;
    last_cnt   = count_q - CNT_W'(1);
    last_idx   = last_cnt[IDX_W-1:0];
    full       = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q >= CNT_W'(MAX_SERVERS));
    pick_ok    = (act_q == rrsp_pkg::ACT_PICK) && (cmd_i.status == rrsp_pkg::ST_OK);

    if (scan_issue) begin
      rd_addr = ptr_q[IDX_W-1:0];
    end else begin
      case (cmd_i.rd_sel)
        rrsp_pkg::RD_LAST: rd_addr = last_idx;
        rrsp_pkg::RD_REM:  rd_addr = rem[IDX_W-1:0];
        default:           rd_addr = last_idx;
      endcase
    end

    case (cmd_i.wr_sel)
      rrsp_pkg::WR_COUNT: wr_addr = count_q[IDX_W-1:0];
      rrsp_pkg::WR_HIT:   wr_addr = hit_idx_q;
      rrsp_pkg::WR_LAST:  wr_addr = last_idx;
      default:            wr_addr = last_idx;
    endcase

    case (cmd_i.data_sel)
      rrsp_pkg::DATA_ID:    wr_data = id_q;
      rrsp_pkg::DATA_MOVED: wr_data = rd_q;
      rrsp_pkg::DATA_ZERO:  wr_data = '0;
      default:              wr_data = '0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = last_cnt;
    end

    rot_d = rot_q;
    if (cmd_i.load_out && pick_ok) begin
      rot_d = rot_q + ROT_W'(1);
    end

    ptr_d   = ptr_q;
    cmp_v_d = cmp_v_q;
    if (in_accept_i) begin
      ptr_d   = '0;
      cmp_v_d = 1'b0;
    end else if (cmd_i.scan_en) begin
      cmp_v_d = ptr_lt;
      if (ptr_lt) begin
        ptr_d = ptr_q + CNT_W'(1);
      end
    end

    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      slots_q[wr_addr] <= wr_data;
    end
    if (rd_fire) begin
      rd_q <= slots_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rot_q       <= '0;
      cap_q       <= rrsp_pkg::CAP_RESET;
      ptr_q       <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rot_q       <= rot_d;
      ptr_q       <= ptr_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      act_q <= rrsp_pkg::action_e'(action_i);
      id_q  <= server_id_i;
    end
    if (cmd_i.scan_en) begin
      hit_idx_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.load_out) begin
      picked_q     <= pick_ok ? rd_q : '0;
      status_q     <= cmd_i.status;
      pool_count_q <= OUT_CNT_W'(count_q);
    end
  end

  always_comb begin
    st_o.act       = act_q;
    st_o.hit       = cmp_v_q && (rd_q == id_q);
    st_o.exhausted = !cmp_v_q && !ptr_lt;
    st_o.full      = full;
    st_o.empty     = (count_q == '0);
    st_o.rem_done  = rem_done;
    st_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign picked_server_o = picked_q;
  assign status_o        = status_q;
  assign pool_count_o    = pool_count_q;

  `RRSP_ASSERT_NEVER(a_count_in_range, count_q > CNT_W'(MAX_SERVERS), "pool count above slots")
  `RRSP_ASSERT(a_append_not_full, (cmd_i.wr_en && cmd_i.data_sel == rrsp_pkg::DATA_ID) |-> !full, "append into full pool")
  `RRSP_ASSERT(a_count_single_step, count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1, "pool count jumped")

endmodule

`default_nettype wire

>>> src/rrsp_ctrl.sv
// ----------------------------------------------------------------------------
// rrsp_ctrl
// sequencer for add, delete, pick and no-op words over the pool datapath
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_server_pool_defines.svh"

module rrsp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_accept_i,
  input  wire rrsp_pkg::dp_status_t st_i,
  output logic                      in_stall_o,
  output rrsp_pkg::ctrl_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_APPEND  = 4'd3;
  localparam logic [3:0] S_MOVE_RD = 4'd4;
  localparam logic [3:0] S_MOVE_WR = 4'd5;
  localparam logic [3:0] S_CLEAR   = 4'd6;
  localparam logic [3:0] S_DIV     = 4'd7;
  localparam logic [3:0] S_PICK_RD = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]        state_q, state_d;
  rrsp_pkg::status_e stat_q, stat_d;

  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    cmd_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st_i.act) inside
          rrsp_pkg::ACT_ADD, rrsp_pkg::ACT_DEL: begin
            state_d = S_SCAN;
          end
          rrsp_pkg::ACT_PICK: begin
            if (st_i.empty) begin
              stat_d  = rrsp_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          default: begin
            stat_d  = rrsp_pkg::ST_OK;
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (st_i.hit) begin
          if (st_i.act == rrsp_pkg::ACT_ADD) begin
            stat_d  = rrsp_pkg::ST_PRESENT;
            state_d = S_DONE;
          end else begin
            state_d = S_MOVE_RD;
          end
        end else if (st_i.exhausted) begin
          if (st_i.act == rrsp_pkg::ACT_ADD) begin
            if (st_i.full) begin
              stat_d  = rrsp_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              state_d = S_APPEND;
            end
          end else begin
            stat_d  = rrsp_pkg::ST_NOT_FOUND;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      S_APPEND: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = rrsp_pkg::WR_COUNT;
        cmd_o.data_sel = rrsp_pkg::DATA_ID;
        cmd_o.cnt_inc  = 1'b1;
        stat_d         = rrsp_pkg::ST_OK;
        state_d        = S_DONE;
      end
      S_MOVE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = rrsp_pkg::RD_LAST;
        state_d      = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = rrsp_pkg::WR_HIT;
        cmd_o.data_sel = rrsp_pkg::DATA_MOVED;
        state_d        = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = rrsp_pkg::WR_LAST;
        cmd_o.data_sel = rrsp_pkg::DATA_ZERO;
        cmd_o.cnt_dec  = 1'b1;
        stat_d         = rrsp_pkg::ST_OK;
        state_d        = S_DONE;
      end
      S_DIV: begin
        if (st_i.rem_done) begin
          state_d = S_PICK_RD;
        end
      end
      S_PICK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = rrsp_pkg::RD_REM;
        stat_d       = rrsp_pkg::ST_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        cmd_o.status = stat_q;
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stat_q  <= rrsp_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `RRSP_ASSERT(a_load_needs_room, cmd_o.load_out |-> st_i.out_free, "result load over waiting word")

endmodule

`default_nettype wire
